// ----- hw/rtl/pds_pkg.sv -----
`default_nettype none

package pds_pkg;

    localparam int DIV_W  = 30;
    localparam int CNT_W  = 5;
    localparam int TGT_W  = 28;
    localparam int XTAL_W = 28;
    localparam int FBI_W  = 30;
    localparam int OI_W   = 12;
    localparam int QM_W   = 2;
    localparam int POST_W = 18;

    localparam logic [DIV_W-1:0]  VCO_MIN_HZ       = 30'd600000000;
    localparam logic [DIV_W-1:0]  DIV_MAX          = 30'd2048;
    localparam logic [TGT_W-1:0]  QUARTER_ABOVE_HZ = 28'd150000000;
    localparam logic [TGT_W-1:0]  SIX_ABOVE_HZ     = 28'd100000000;
    localparam logic [TGT_W-1:0]  EIGHT_ABOVE_HZ   = 28'd75000000;
    localparam logic [TGT_W-1:0]  TARGET_LOW       = 28'd3;
    localparam logic [TGT_W-1:0]  TARGET_HIGH      = 28'd199999999;
    localparam logic [XTAL_W-1:0] XTAL_RESET       = 28'd25000000;
    localparam logic [QM_W-1:0]   QUARTER_CODE     = 2'd3;
    localparam logic [QM_W-1:0]   NORMAL_CODE      = 2'd0;
    localparam logic [OI_W-1:0]   DIV_QUARTER      = 12'd4;
    localparam logic [OI_W-1:0]   DIV_SIX          = 12'd6;
    localparam logic [OI_W-1:0]   DIV_EIGHT        = 12'd8;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quot;
        logic [DIV_W-1:0] rem;
    } t_div_rsp;

endpackage

`default_nettype wire

// ----- hw/rtl/pds_div.sv -----
`default_nettype none

module pds_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire pds_pkg::t_div_req i_req,
    output pds_pkg::t_div_rsp      o_rsp
);
    import pds_pkg::*;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DIV_W-1:0] r_rem;
    logic [DIV_W-1:0] r_quot;
    logic [DIV_W-1:0] r_dvs;
    logic [DIV_W:0]   trial;
    logic [DIV_W:0]   diff;
    logic             ge;

    assign trial = {r_rem, r_quot[DIV_W-1]};
    assign diff  = trial - {1'b0, r_dvs};
    assign ge    = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one quotient bit per cycle, restoring
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_quot <= i_req.dividend;
            r_rem  <= '0;
            r_dvs  <= i_req.divisor;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
            r_quot <= {r_quot[DIV_W-2:0], ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quot = r_quot;
    assign o_rsp.rem  = r_rem;

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy)
        else $error("divider restarted while busy");

    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> ($past(r_busy) && !r_busy))
        else $error("divider done without a run");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_done && r_dvs != '0) |-> (r_rem < r_dvs))
        else $error("remainder not below divisor");

endmodule

`default_nettype wire

// ----- hw/rtl/pll_divider_seek.sv -----
// pll_divider_seek
// Computes clock synthesizer divider settings for a wanted output frequency.
// Input channel: i_valid / o_ready carry one word, i_target_hz in hertz.
// Output channel: o_valid / i_ready carry one result word on the o_* fields.
// Configuration: i_cfg_we writes i_cfg_wdata into the crystal frequency
// register; write it only while no word is in flight. A value of 0 acts as 1.
// Work: a word takes s output divider trials (1 to 18, none above 75 MHz)
// and g gcd remainder steps (at most about 41), each one division. Every division
// runs on one shared 30-bit restoring divider at one quotient bit per cycle;
// an out-of-range target skips the divider.
// Throughput: one word at a time; o_ready is low while a word is computed.
// The finished result sits in an output register, so the next word is taken
// while it waits; if the receiver still stalls when the next result is done,
// the block holds that result until the register frees up.
// Reset (synchronous, active low) empties the block and sets the crystal
// register to 25000000.
`default_nettype none

module pll_divider_seek (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_cfg_we,
    input  wire logic [pds_pkg::XTAL_W-1:0]  i_cfg_wdata,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [pds_pkg::TGT_W-1:0]   i_target_hz,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [pds_pkg::FBI_W-1:0]        o_feedback_integer,
    output logic [pds_pkg::XTAL_W-1:0]       o_feedback_numerator,
    output logic [pds_pkg::XTAL_W-1:0]       o_feedback_denominator,
    output logic [pds_pkg::OI_W-1:0]         o_output_integer,
    output logic                             o_output_numerator,
    output logic                             o_output_denominator,
    output logic [pds_pkg::QM_W-1:0]         o_quarter_mode,
    output logic [pds_pkg::POST_W-1:0]       o_post_divider,
    output logic                             o_range_error
);
    import pds_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_SEEK = 8'b0000_0010,
        S_MUL  = 8'b0000_0100,
        S_FB   = 8'b0000_1000,
        S_GCD  = 8'b0001_0000,
        S_RNUM = 8'b0010_0000,
        S_RDEN = 8'b0100_0000,
        S_OUT  = 8'b1000_0000
    } t_state;

    t_state              r_state;
    t_state              n_state;
    logic [XTAL_W-1:0]   r_crystal_hz;
    logic [XTAL_W-1:0]   xtal;
    logic                r_start;
    logic                r_err;
    logic [TGT_W-1:0]    r_d;
    logic [POST_W-1:0]   r_post;
    logic [OI_W-1:0]     r_div;
    logic [OI_W-1:0]     r_out_int;
    logic [QM_W-1:0]     r_quarter;
    logic [FBI_W-1:0]    r_vco;
    logic [FBI_W-1:0]    r_fb_int;
    logic [XTAL_W-1:0]   r_num;
    logic [XTAL_W-1:0]   r_den;
    logic [XTAL_W-1:0]   r_a;
    logic [XTAL_W-1:0]   r_b;
    logic                r_out_valid;
    logic [TGT_W+OI_W-1:0] prod;
    logic                accept;
    logic                in_range;
    logic                out_free;
    t_div_req            div_req;
    t_div_rsp            div_rsp;

    assign xtal     = (r_crystal_hz == '0) ? XTAL_W'(1) : r_crystal_hz;
    assign accept   = i_valid && o_ready;
    assign in_range = (i_target_hz >= TARGET_LOW) && (i_target_hz <= TARGET_HIGH);
    assign out_free = !r_out_valid || i_ready;
    assign prod     = r_d * r_div;
    assign o_ready  = (r_state == S_IDLE);

    pds_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_comb begin
        div_req.start    = r_start;
        div_req.dividend = VCO_MIN_HZ;
        div_req.divisor  = DIV_W'(r_d);
        case (r_state)
            S_FB: begin
                div_req.dividend = r_vco;
                div_req.divisor  = DIV_W'(xtal);
            end
            S_GCD: begin
                div_req.dividend = DIV_W'(r_a);
                div_req.divisor  = DIV_W'(r_b);
            end
            S_RNUM: begin
                div_req.dividend = DIV_W'(r_num);
                div_req.divisor  = DIV_W'(r_a);
            end
            S_RDEN: begin
                div_req.dividend = DIV_W'(xtal);
                div_req.divisor  = DIV_W'(r_a);
            end
            default: begin
                div_req.dividend = VCO_MIN_HZ;
                div_req.divisor  = DIV_W'(r_d);
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (!in_range) begin
                        n_state = S_OUT;
                    end else if (i_target_hz > EIGHT_ABOVE_HZ) begin
                        n_state = S_MUL;
                    end else begin
                        n_state = S_SEEK;
                    end
                end
            end
            S_SEEK: begin
                if (div_rsp.done && div_rsp.quot < DIV_MAX) begin
                    n_state = S_MUL;
                end
            end
            S_MUL:  n_state = S_FB;
            S_FB: begin
                if (div_rsp.done) begin
                    n_state = S_GCD;
                end
            end
            S_GCD: begin
                if (div_rsp.done && div_rsp.rem == '0) begin
                    n_state = S_RNUM;
                end
            end
            S_RNUM: begin
                if (div_rsp.done) begin
                    n_state = S_RDEN;
                end
            end
            S_RDEN: begin
                if (div_rsp.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_start      <= 1'b0;
            r_out_valid  <= 1'b0;
            r_crystal_hz <= XTAL_RESET;
        end else begin
            r_state <= n_state;
            r_start <= 1'b0;
            if (i_cfg_we) begin
                r_crystal_hz <= i_cfg_wdata;
            end
            if (r_state == S_IDLE && accept && in_range
                    && i_target_hz <= EIGHT_ABOVE_HZ) begin
                r_start <= 1'b1;
            end
            if (div_rsp.done) begin
                case (r_state)
                    S_SEEK:  r_start <= (div_rsp.quot >= DIV_MAX);
                    S_FB:    r_start <= 1'b1;
                    S_GCD:   r_start <= 1'b1;
                    S_RNUM:  r_start <= 1'b1;
                    default: r_start <= 1'b0;
                endcase
            end
            if (r_state == S_MUL) begin
                r_start <= 1'b1;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_err     <= !in_range;
                    r_d       <= i_target_hz;
                    r_post    <= POST_W'(1);
                    r_quarter <= NORMAL_CODE;
                    if (i_target_hz > QUARTER_ABOVE_HZ) begin
                        r_quarter <= QUARTER_CODE;
                        r_div     <= DIV_QUARTER;
                        r_out_int <= '0;
                    end else if (i_target_hz > SIX_ABOVE_HZ) begin
                        r_div     <= DIV_SIX;
                        r_out_int <= DIV_SIX;
                    end else begin
                        r_div     <= DIV_EIGHT;
                        r_out_int <= DIV_EIGHT;
                    end
                end
            end
            S_SEEK: begin
                if (div_rsp.done) begin
                    if (div_rsp.quot >= DIV_MAX) begin
                        r_d    <= {r_d[TGT_W-2:0], 1'b0};
                        r_post <= {r_post[POST_W-2:0], 1'b0};
                    end else begin
                        r_div     <= div_rsp.quot[OI_W-1:0] + OI_W'(1);
                        r_out_int <= div_rsp.quot[OI_W-1:0] + OI_W'(1);
                    end
                end
            end
            S_MUL: r_vco <= prod[FBI_W-1:0];
            S_FB: begin
                if (div_rsp.done) begin
                    r_fb_int <= div_rsp.quot;
                    r_num    <= div_rsp.rem[XTAL_W-1:0];
                    r_a      <= div_rsp.rem[XTAL_W-1:0];
                    r_b      <= xtal;
                end
            end
            S_GCD: begin
                if (div_rsp.done) begin
                    r_a <= r_b;
                    r_b <= div_rsp.rem[XTAL_W-1:0];
                end
            end
            S_RNUM: begin
                if (div_rsp.done) begin
                    r_num <= div_rsp.quot[XTAL_W-1:0];
                end
            end
            S_RDEN: begin
                if (div_rsp.done) begin
                    r_den <= div_rsp.quot[XTAL_W-1:0];
                end
            end
            S_OUT: begin
                if (out_free) begin
                    o_range_error          <= r_err;
                    o_feedback_integer     <= r_err ? '0 : r_fb_int;
                    o_feedback_numerator   <= r_err ? '0 : r_num;
                    o_feedback_denominator <= r_err ? '0 : r_den;
                    o_output_integer       <= r_err ? '0 : r_out_int;
                    o_output_denominator   <= !r_err;
                    o_quarter_mode         <= r_err ? NORMAL_CODE : r_quarter;
                    o_post_divider         <= r_err ? '0 : r_post;
                end
            end
            default: r_vco <= r_vco;
        endcase
    end

    assign o_valid            = r_out_valid;
    assign o_output_numerator = 1'b0;

    a_start_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> (r_state != S_IDLE && r_state != S_OUT && r_state != S_MUL))
        else $error("division started outside a division step");

    a_out_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> (o_valid && r_state == S_IDLE))
        else $error("finished result not posted");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !accept)
        else $error("word taken during computation");

endmodule

`default_nettype wire

// ----- bench/tb_pll_divider_seek.sv -----
`default_nettype none

module tb_pll_divider_seek;

    import pds_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 2200;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        logic [FBI_W-1:0]  fb_integer;
        logic [XTAL_W-1:0] fb_numerator;
        logic [XTAL_W-1:0] fb_denominator;
        logic [OI_W-1:0]   out_integer;
        logic              out_numerator;
        logic              out_denominator;
        logic [QM_W-1:0]   quarter;
        logic [POST_W-1:0] post;
        logic              range_err;
    } t_divider_word;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    logic [XTAL_W-1:0]   i_cfg_wdata = '0;
    logic                i_valid = 1'b0;
    logic                o_ready;
    logic [TGT_W-1:0]    i_target_hz = '0;
    logic                o_valid;
    logic                i_ready = 1'b0;
    logic [FBI_W-1:0]    o_feedback_integer;
    logic [XTAL_W-1:0]   o_feedback_numerator;
    logic [XTAL_W-1:0]   o_feedback_denominator;
    logic [OI_W-1:0]     o_output_integer;
    logic                o_output_numerator;
    logic                o_output_denominator;
    logic [QM_W-1:0]     o_quarter_mode;
    logic [POST_W-1:0]   o_post_divider;
    logic                o_range_error;

    logic [TGT_W-1:0]    pending_targets[$];
    t_divider_word       expected_words[$];
    logic [XTAL_W-1:0]   crystal_copy = XTAL_RESET;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  mismatch_count = 0;
    int                  stuck_cycles = 0;

    pll_divider_seek dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_cfg_we               (i_cfg_we),
        .i_cfg_wdata            (i_cfg_wdata),
        .i_valid                (i_valid),
        .o_ready                (o_ready),
        .i_target_hz            (i_target_hz),
        .o_valid                (o_valid),
        .i_ready                (i_ready),
        .o_feedback_integer     (o_feedback_integer),
        .o_feedback_numerator   (o_feedback_numerator),
        .o_feedback_denominator (o_feedback_denominator),
        .o_output_integer       (o_output_integer),
        .o_output_numerator     (o_output_numerator),
        .o_output_denominator   (o_output_denominator),
        .o_quarter_mode         (o_quarter_mode),
        .o_post_divider         (o_post_divider),
        .o_range_error          (o_range_error)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    function automatic t_divider_word predict_dividers(input logic [TGT_W-1:0] f,
                                                       input logic [XTAL_W-1:0] xtal_reg);
        t_divider_word w;
        logic [63:0]   xtal;
        logic [63:0]   div;
        logic [63:0]   post;
        logic [63:0]   vco;
        logic [63:0]   a;
        logic [63:0]   b;
        logic [63:0]   r;
        w = '0;
        if (f < TARGET_LOW || f > TARGET_HIGH) begin
            w.range_err = 1'b1;
            return w;
        end
        xtal = (xtal_reg == '0) ? 64'd1 : 64'(xtal_reg);
        post = 64'd1;
        w.quarter = NORMAL_CODE;
        if (f > QUARTER_ABOVE_HZ) begin
            w.quarter = QUARTER_CODE;
            w.out_integer = '0;
            div = 64'(DIV_QUARTER);
        end else if (f > SIX_ABOVE_HZ) begin
            div = 64'(DIV_SIX);
            w.out_integer = DIV_SIX;
        end else if (f > EIGHT_ABOVE_HZ) begin
            div = 64'(DIV_EIGHT);
            w.out_integer = DIV_EIGHT;
        end else begin
            div = 64'(VCO_MIN_HZ) / 64'(f) + 64'd1;
            while (div > 64'(DIV_MAX)) begin
                post = post * 64'd2;
                div = 64'(VCO_MIN_HZ) / (post * 64'(f)) + 64'd1;
            end
            w.out_integer = div[OI_W-1:0];
        end
        vco = 64'(f) * div * post;
        a = vco % xtal;
        b = xtal;
        w.fb_integer = FBI_W'(vco / xtal);
        while (b != 64'd0) begin
            r = a % b;
            a = b;
            b = r;
        end
        w.fb_numerator = XTAL_W'((vco % xtal) / a);
        w.fb_denominator = XTAL_W'(xtal / a);
        w.out_numerator = 1'b0;
        w.out_denominator = 1'b1;
        w.post = post[POST_W-1:0];
        return w;
    endfunction

    localparam int N_EDGES = 20;
    logic [TGT_W-1:0] edge_targets[N_EDGES] = '{
        28'd0, 28'd1, 28'd2, 28'd3, 28'd4, 28'd199999999, 28'd200000000,
        28'd268435455, 28'd150000001, 28'd150000000, 28'd100000001,
        28'd100000000, 28'd75000001, 28'd75000000, 28'd292969, 28'd292968,
        28'd25000000, 28'd12500000, 28'd10000000, 28'd1000
    };

    function automatic logic [TGT_W-1:0] pick_target();
        int unsigned bits;
        int unsigned v;
        case ($urandom_range(9))
            0: begin
                if ($urandom_range(1) == 0)
                    v = $urandom_range(2);
                else
                    v = $urandom_range(268435455, 200000000);
            end
            1: v = $urandom_range(199999999, 150000001);
            2: v = $urandom_range(150000000, 100000001);
            3: v = $urandom_range(100000000, 75000001);
            4: v = $urandom & 32'h0FFF_FFFF;
            5: v = edge_targets[$urandom_range(N_EDGES - 1)];
            default: begin
                bits = $urandom_range(27, 2);
                v = $urandom_range((1 << bits) - 1, 1 << (bits - 1));
                if (v > EIGHT_ABOVE_HZ)
                    v = $urandom_range(EIGHT_ABOVE_HZ, TARGET_LOW);
            end
        endcase
        return TGT_W'(v);
    endfunction

    // input side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || o_ready) begin
            if (i_valid)
                expected_words.push_back(predict_dividers(i_target_hz, crystal_copy));
            if (pending_targets.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                i_valid <= 1'b1;
                i_target_hz <= pending_targets.pop_front();
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // output side and watchdog
    always @(posedge i_clk) begin
        t_divider_word got;
        t_divider_word want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                got = {o_feedback_integer, o_feedback_numerator, o_feedback_denominator,
                       o_output_integer, o_output_numerator, o_output_denominator,
                       o_quarter_mode, o_post_divider, o_range_error};
                if (expected_words.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("unexpected result word: %p", got);
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("mismatch fb_int %0d/%0d num %0d/%0d den %0d/%0d",
                                     want.fb_integer, got.fb_integer,
                                     want.fb_numerator, got.fb_numerator,
                                     want.fb_denominator, got.fb_denominator);
                            $display("  out_int %0d/%0d num %0d/%0d den %0d/%0d",
                                     want.out_integer, got.out_integer,
                                     want.out_numerator, got.out_numerator,
                                     want.out_denominator, got.out_denominator);
                            $display("  quarter %0d/%0d post %0d/%0d range_err %0d/%0d",
                                     want.quarter, got.quarter, want.post, got.post,
                                     want.range_err, got.range_err);
                        end
                    end
                end
            end
            i_ready <= ($urandom_range(99) >= recv_idle_pct);
            if ((i_valid && o_ready) || (o_valid && i_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    task automatic wait_drained();
        while (pending_targets.size() != 0 || i_valid || expected_words.size() != 0)
            @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_crystal(input logic [XTAL_W-1:0] value);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        crystal_copy = value;
    endtask

    task automatic queue_random(input int count);
        repeat (count) pending_targets.push_back(pick_target());
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        send_idle_pct = 12;
        recv_idle_pct = 80;
        repeat (2) @(posedge i_clk);

        foreach (edge_targets[k]) pending_targets.push_back(edge_targets[k]);
        queue_random(10);
        wait_drained();

        write_crystal(28'd27000000);
        queue_random(15);
        wait_drained();

        send_idle_pct = 80;
        recv_idle_pct = 12;
        // zero crystal behaves as one
        write_crystal(28'd0);
        queue_random(20);
        wait_drained();

        write_crystal(28'd268435455);
        queue_random(15);
        wait_drained();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_crystal(28'd1);
        queue_random(20);
        wait_drained();

        write_crystal(28'd200000000);
        queue_random(20);
        wait_drained();

        write_crystal(XTAL_W'($urandom));
        queue_random(20);
        wait_drained();

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- pll_divider_seek.f -----
hw/rtl/pds_pkg.sv
hw/rtl/pds_div.sv
hw/rtl/pll_divider_seek.sv
bench/tb_pll_divider_seek.sv
